// ===== rtl/rcpa_pkg.sv =====
// shared types and constants for the reference-counted page allocator
`default_nettype none

package rcpa_pkg;

  localparam int FUP_W    = 12;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int STATUS_W = 3;
  localparam int ALLOC_W  = 24;
  localparam int COUNT_W  = 8;
  localparam int ADDR_W   = 32;

  localparam logic [0:0] REG_FIRST_USABLE = 1'b0;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_ADDREF = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOMEM    = 3'd1,
    ST_BADADDR  = 3'd2,
    ST_UNREF    = 3'd3,
    ST_REFD     = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/rcpa_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module rcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/rcpa_apb.sv =====
// apb register block holding the first usable page index
`default_nettype none

module rcpa_apb
  import rcpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output logic      [FUP_W-1:0]  first_usable
);

  logic [FUP_W-1:0] first_r;
  logic [FUP_W-1:0] first_nxt;
  logic             sel_first;

  assign sel_first = (paddr[CFG_AW-1:2] == REG_FIRST_USABLE);

  always_comb begin
    first_nxt = first_r;
    if (psel && penable && pwrite && sel_first) begin
      first_nxt = pwdata[FUP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
    end else begin
      first_r <= first_nxt;
    end
  end

  assign prdata       = sel_first ? CFG_DW'(first_r) : '0;
  assign pready       = 1'b1;
  assign first_usable = first_r;

endmodule

`default_nettype wire

// ===== rtl/refcounted_page_allocator.sv =====
// top level: page allocator with lifo free list and per-page reference counts
//
//  port group | dir | handshake           | word
//  in_        | in  | in_valid / in_stall   | opcode, page_address
//  out_       | out | out_valid / out_stall | status, allocated_address, reference_count,
//             |     |                       | page_released
//  cfg_       | in  | apb psel / penable    | first_usable_page at byte address 0
//
// an item passes S_IDLE then S_CNT, with S_STK between when allocate pops the free stack
// (stack read, then count read), as the stack and count memories have registered read data
// after reset the count memory is cleared in S_CLEAR, with in_stall high
// a result waits in the output register; a stalled output holds the next item in its count turn
`default_nettype none

module refcounted_page_allocator
  import rcpa_pkg::*;
#(
  parameter int PAGE_SIZE  = 4096,
  parameter int NUM_PAGES  = 4096,
  parameter int COUNT_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_opcode,
  input  wire logic [ADDR_W-1:0]   in_page_address,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [ALLOC_W-1:0]  out_allocated_address,
  output logic      [COUNT_W-1:0]  out_reference_count,
  output logic                     out_page_released,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CFG_AW-1:0]   cfg_paddr,
  input  wire logic [CFG_DW-1:0]   cfg_pwdata,
  output logic      [CFG_DW-1:0]   cfg_prdata,
  output logic                     cfg_pready
);

  localparam int PAGE_BITS = $clog2(NUM_PAGES);
  localparam int OFF_BITS  = $clog2(PAGE_SIZE);
  localparam int DW        = $clog2(NUM_PAGES + 1);
  localparam int FULL_W    = PAGE_BITS + OFF_BITS + ALLOC_W;
  localparam int CXW       = COUNT_BITS + COUNT_W;
  localparam int IDX_W     = ADDR_W - OFF_BITS;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_STK,
    S_CNT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [PAGE_BITS-1:0]   clr_r, clr_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [PAGE_BITS-1:0]   page_r, page_nxt;
  logic                   bad_r, bad_nxt;
  logic                   nomem_r, nomem_nxt;
  logic [DW-1:0]          depth_r, depth_nxt;
  logic [DW-1:0]          fresh_r, fresh_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [ALLOC_W-1:0]     alloc_r, alloc_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic                   rel_r, rel_nxt;

  logic [FUP_W-1:0]       first_usable;
  logic [IDX_W-1:0]       idx;
  logic                   addr_ok;
  logic                   has_stack;
  logic                   has_fresh;
  logic [PAGE_BITS-1:0]   in_page;

  logic                   cnt_we;
  logic [PAGE_BITS-1:0]   cnt_waddr;
  logic [COUNT_BITS-1:0]  cnt_wdata;
  logic [PAGE_BITS-1:0]   cnt_raddr;
  logic [COUNT_BITS-1:0]  cnt_rdata;
  logic                   stk_we;
  logic [PAGE_BITS-1:0]   stk_rdata;

  logic                   load;
  logic [COUNT_BITS-1:0]  cnt_res;
  logic [COUNT_BITS-1:0]  cnt_dec;
  logic [FULL_W-1:0]      addr_full;
  logic [CXW-1:0]         cnt_ext;

  rcpa_apb u_apb (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .first_usable (first_usable)
  );

  rcpa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_PAGES)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  rcpa_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (NUM_PAGES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (depth_r[PAGE_BITS-1:0]),
    .wdata (page_r),
    .raddr (PAGE_BITS'(depth_r - DW'(1))),
    .rdata (stk_rdata)
  );

  // address decode for free, add-reference and query
  assign idx     = in_page_address[ADDR_W-1:OFF_BITS];
  assign addr_ok = (in_page_address[OFF_BITS-1:0] == '0)
                && ((ADDR_W+1)'(idx) < (ADDR_W+1)'(NUM_PAGES))
                && ((ADDR_W+1)'(idx) >= (ADDR_W+1)'(first_usable));

  assign has_stack = (depth_r != '0);
  assign has_fresh = (ADDR_W'(fresh_r) > ADDR_W'(first_usable));

  always_comb begin
    if (in_opcode == OP_ALLOC) begin
      in_page = PAGE_BITS'(fresh_r - DW'(1));
    end else begin
      in_page = idx[PAGE_BITS-1:0];
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:  cnt_raddr = in_page;
      S_STK:   cnt_raddr = stk_rdata;
      default: cnt_raddr = page_r;
    endcase
  end

  assign load      = !out_valid_r || !out_stall;
  assign cnt_dec   = cnt_rdata - COUNT_BITS'(1);
  assign addr_full = FULL_W'(page_r) << OFF_BITS;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    page_nxt      = page_r;
    bad_nxt       = bad_r;
    nomem_nxt     = nomem_r;
    depth_nxt     = depth_r;
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    alloc_nxt     = alloc_r;
    count_nxt     = count_r;
    rel_nxt       = rel_r;
    cnt_we        = 1'b0;
    cnt_waddr     = page_r;
    cnt_wdata     = '0;
    stk_we        = 1'b0;
    cnt_res       = '0;
    cnt_ext       = '0;

    unique case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        clr_nxt   = clr_r + PAGE_BITS'(1);
        if (clr_r == PAGE_BITS'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          page_nxt  = in_page;
          bad_nxt   = 1'b0;
          nomem_nxt = 1'b0;
          state_nxt = S_CNT;
          if (in_opcode == OP_ALLOC) begin
            if (has_stack) begin
              depth_nxt = depth_r - DW'(1);
              state_nxt = S_STK;
            end else if (has_fresh) begin
              fresh_nxt = fresh_r - DW'(1);
            end else begin
              nomem_nxt = 1'b1;
            end
          end else begin
            bad_nxt = !addr_ok;
          end
        end
      end

      S_STK: begin
        page_nxt  = stk_rdata;
        state_nxt = S_CNT;
      end

      S_CNT: begin
        if (load) begin
          status_nxt = ST_OK;
          alloc_nxt  = '0;
          rel_nxt    = 1'b0;
          if (op_r == OP_ALLOC) begin
            if (nomem_r) begin
              status_nxt = ST_NOMEM;
            end else if (cnt_rdata != '0) begin
              status_nxt = ST_REFD;
              cnt_res    = cnt_rdata;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = COUNT_BITS'(1);
              cnt_res   = COUNT_BITS'(1);
              alloc_nxt = addr_full[ALLOC_W-1:0];
            end
          end else if (bad_r) begin
            status_nxt = ST_BADADDR;
          end else begin
            case (op_r)
              OP_FREE: begin
                if (cnt_rdata == '0) begin
                  status_nxt = ST_UNREF;
                end else begin
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_dec;
                  cnt_res   = cnt_dec;
                  if (cnt_dec == '0) begin
                    rel_nxt = 1'b1;
                    if (depth_r != DW'(NUM_PAGES)) begin
                      stk_we    = 1'b1;
                      depth_nxt = depth_r + DW'(1);
                    end
                  end
                end
              end
              OP_ADDREF: begin
                if (cnt_rdata == '1) begin
                  status_nxt = ST_OVERFLOW;
                  cnt_res    = cnt_rdata;
                end else begin
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_rdata + COUNT_BITS'(1);
                  cnt_res   = cnt_rdata + COUNT_BITS'(1);
                end
              end
              default: begin
                cnt_res = cnt_rdata;
              end
            endcase
          end
          cnt_ext       = CXW'(cnt_res);
          count_nxt     = cnt_ext[COUNT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      depth_r     <= '0;
      fresh_r     <= DW'(NUM_PAGES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      depth_r     <= depth_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r     <= op_nxt;
    page_r   <= page_nxt;
    bad_r    <= bad_nxt;
    nomem_r  <= nomem_nxt;
    status_r <= status_nxt;
    alloc_r  <= alloc_nxt;
    count_r  <= count_nxt;
    rel_r    <= rel_nxt;
  end

  assign in_stall              = (state_r != S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_allocated_address = alloc_r;
  assign out_reference_count   = count_r;
  assign out_page_released     = rel_r;

endmodule

`default_nettype wire
